// ===== hdl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 code point decoder.
`default_nettype none

package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 31;
    localparam int REM_W  = 3;
    localparam int BITS_PER_CONT = 6;

    localparam logic [BYTE_W-1:0] END_BYTE = 8'h00;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [REM_W-1:0] bytes_remaining;
        logic [CP_W-1:0]  partial_code;
    } u8d_state_t;

    // One decoded result, plus a flag that says whether the byte made one.
    typedef struct packed {
        logic            has_result;
        logic [CP_W-1:0] code_point;
        logic            end_of_text;
    } u8d_result_t;

    localparam u8d_state_t STATE_RESET = '{bytes_remaining: '0, partial_code: '0};

endpackage

`default_nettype wire

// ===== hdl/u8d_decode.sv =====
// Combinational decode of one byte against the current sequence state.
`default_nettype none

module u8d_decode
    import u8d_pkg::*;
(
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire u8d_state_t        state_cur,
    output u8d_state_t             state_next,
    output u8d_result_t            result
);

    logic [CP_W-1:0] appended;

    assign appended = {state_cur.partial_code[CP_W-BITS_PER_CONT-1:0],
                       byte_in[BITS_PER_CONT-1:0]};

    always_comb
    begin
        state_next         = state_cur;
        result.has_result  = 1'b0;
        result.code_point  = '0;
        result.end_of_text = 1'b0;

        if (byte_in == END_BYTE)
        begin
            // End of text: drop any partial sequence.
            state_next         = STATE_RESET;
            result.has_result  = 1'b1;
            result.end_of_text = 1'b1;
        end
        else if (state_cur.bytes_remaining != '0)
        begin
            // Continuation position; pattern is not checked.
            state_next.bytes_remaining = state_cur.bytes_remaining - REM_W'(1);
            state_next.partial_code    = appended;
            if (state_cur.bytes_remaining == REM_W'(1))
            begin
                result.has_result       = 1'b1;
                result.code_point       = appended;
                state_next.partial_code = '0;
            end
        end
        else if (!byte_in[7])
        begin
            result.has_result = 1'b1;
            result.code_point = CP_W'(byte_in);
        end
        else if (!byte_in[6])
        begin
            // stray continuation byte: dropped
        end
        else if (!byte_in[5])
        begin
            state_next.bytes_remaining = REM_W'(1);
            state_next.partial_code    = CP_W'(byte_in[4:0]);
        end
        else if (!byte_in[4])
        begin
            state_next.bytes_remaining = REM_W'(2);
            state_next.partial_code    = CP_W'(byte_in[3:0]);
        end
        else if (!byte_in[3])
        begin
            state_next.bytes_remaining = REM_W'(3);
            state_next.partial_code    = CP_W'(byte_in[2:0]);
        end
        else if (!byte_in[2])
        begin
            state_next.bytes_remaining = REM_W'(4);
            state_next.partial_code    = CP_W'(byte_in[1:0]);
        end
        else if (!byte_in[1])
        begin
            state_next.bytes_remaining = REM_W'(5);
            state_next.partial_code    = CP_W'(byte_in[0]);
        end
        else
        begin
            // 0xFE / 0xFF: dropped
        end
    end

endmodule

`default_nettype wire

// ===== hdl/utf8_code_point_decoder.sv =====
// Top level: input register, byte decode and result register.
`default_nettype none

// UTF-8 code point decoder. One text byte enters per transfer on the in_*
// channel; each completed code point (or end-of-text marker) leaves as one
// transfer on the out_* channel. Bytes below 0x80 come out as themselves; a
// lead byte with 2 to 6 leading ones opens a sequence and the next n-1 bytes
// each add their low six bits, unchecked. Stray continuation bytes and
// 0xFE/0xFF in lead position are dropped with no result. A zero byte gives
// one result with end_of_text = 1 and code_point = 0 and clears any partial
// sequence. Throughput is one byte per clock unless the input register holds:
// a byte is registered, decoded against the sequence state and the result
// registered. The input register only holds when a result is waiting in the
// output register and out_ready is low; bytes that make no result pass even
// then.
module utf8_code_point_decoder
    import u8d_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] text_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CP_W-1:0]        code_point,
    output logic                   end_of_text
);

    // Input register stage.
    logic              byte_valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    // Sequence state.
    u8d_state_t        state_reg;
    u8d_state_t        state_next;

    // Result register.
    logic              res_valid_reg;
    logic [CP_W-1:0]   res_code_reg;
    logic              res_eot_reg;

    u8d_result_t       dec_result;
    logic              advance;
    logic              res_free;

    u8d_decode u_decode (
        .byte_in    (byte_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (dec_result)
    );

    assign res_free = !res_valid_reg || out_ready;
    // Decoded byte retires if it makes no result or the result slot opens.
    assign advance  = byte_valid_reg && (!dec_result.has_result || res_free);
    assign in_ready = !byte_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            state_reg      <= STATE_RESET;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                byte_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && dec_result.has_result)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= text_byte;
        end
        if (advance && dec_result.has_result)
        begin
            res_code_reg <= dec_result.code_point;
            res_eot_reg  <= dec_result.end_of_text;
        end
    end

    assign out_valid   = res_valid_reg;
    assign code_point  = res_code_reg;
    assign end_of_text = res_eot_reg;

endmodule

`default_nettype wire

// ===== verif/utf8_code_point_decoder_tb.sv =====
// Self-checking testbench for the UTF-8 code point decoder: byte stimulus, scoreboard, watchdog.
`default_nettype none

module utf8_code_point_decoder_tb;
    import u8d_pkg::*;

    // Tracks decoder state alongside the DUT and holds the code points it should emit.
    class code_point_tracker;
        u8d_state_t  seq_state;
        u8d_result_t pending_codes[$];
        int unsigned mismatch_count;

        function new();
            seq_state      = STATE_RESET;
            mismatch_count = 0;
        endfunction

        // Number of leading one bits of a lead byte.
        function automatic int unsigned lead_ones(logic [BYTE_W-1:0] b);
            int unsigned n;
            n = 0;
            while (n < BYTE_W && b[BYTE_W-1-n])
                n++;
            return n;
        endfunction

        // Advance the sequence state by one byte; has_result says whether a code point came out.
        function automatic u8d_result_t decode_byte(logic [BYTE_W-1:0] b);
            u8d_result_t r;
            int unsigned ones;
            r = '0;
            if (b == END_BYTE) begin
                // end of text abandons any partial sequence
                seq_state     = STATE_RESET;
                r.has_result  = 1'b1;
                r.end_of_text = 1'b1;
            end else if (seq_state.bytes_remaining != '0) begin
                // continuation pattern is not checked; low six bits always used
                seq_state.partial_code = {seq_state.partial_code[CP_W-1-BITS_PER_CONT:0],
                                          b[BITS_PER_CONT-1:0]};
                seq_state.bytes_remaining = seq_state.bytes_remaining - 1'b1;
                if (seq_state.bytes_remaining == '0) begin
                    r.has_result           = 1'b1;
                    r.code_point           = seq_state.partial_code;
                    seq_state.partial_code = '0;
                end
            end else if (!b[BYTE_W-1]) begin
                r.has_result = 1'b1;
                r.code_point = CP_W'(b);
            end else begin
                ones = lead_ones(b);
                if (ones >= 2 && ones <= 6) begin
                    seq_state.partial_code    = CP_W'(b & (8'hFF >> ones));
                    seq_state.bytes_remaining = REM_W'(ones - 1);
                end
            end
            return r;
        endfunction

        // Record an accepted byte. Returns 0 when the DUT just drops it.
        function automatic bit note_byte(logic [BYTE_W-1:0] b);
            u8d_result_t r;
            int unsigned ones;
            bit          dropped;
            ones    = lead_ones(b);
            dropped = (seq_state.bytes_remaining == '0) && b[BYTE_W-1] && (ones < 2 || ones > 6);
            r = decode_byte(b);
            if (r.has_result)
                pending_codes.push_back(r);
            return !dropped;
        endfunction

        function automatic void check_result(logic [CP_W-1:0] cp, logic eot);
            u8d_result_t want;
            if (pending_codes.size() == 0) begin
                $display("%0t: result with nothing pending: code_point=%h end_of_text=%b",
                         $time, cp, eot);
                mismatch_count++;
                return;
            end
            want = pending_codes.pop_front();
            if (cp !== want.code_point) begin
                $display("%0t: code_point expected %h actual %h", $time, want.code_point, cp);
                mismatch_count++;
            end
            if (eot !== want.end_of_text) begin
                $display("%0t: end_of_text expected %b actual %b", $time, want.end_of_text, eot);
                mismatch_count++;
            end
        endfunction

        function automatic int unsigned pending();
            return pending_codes.size();
        endfunction
    endclass

    localparam int unsigned RANDOM_CODES = 1650;
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned IDLE_PCT     = 26;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] text_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CP_W-1:0]   code_point;
    logic              end_of_text;

    code_point_tracker tracker = new();

    bit          calm = 1'b0;      // no idling on either side while set
    int unsigned codes_sent = 0;   // accepted bytes the DUT does not drop

    utf8_code_point_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .end_of_text (end_of_text)
    );

    always #2 clk = ~clk;

    function automatic bit take_gap();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Result side: random back-pressure, checked on every output transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(code_point, end_of_text);
        out_ready <= rst_n && !take_gap();
    end

    // Drive one byte and hold it until the transfer. Valid stays up between
    // back-to-back bytes; it only drops when a gap is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (take_gap())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (take_gap())
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (tracker.note_byte(b))
            codes_sent++;
    endtask

    // Lead byte of an n-byte sequence (n = 2..6) with random payload bits.
    function automatic logic [BYTE_W-1:0] lead_byte(int unsigned n);
        logic [BYTE_W-1:0] marker;
        marker = 8'hFF << (BYTE_W - n);
        return marker | (BYTE_W'($urandom) & (8'hFF >> (n + 1)));
    endfunction

    function automatic logic [BYTE_W-1:0] cont_byte();
        return 8'h80 | BYTE_W'($urandom_range(8'h3F));
    endfunction

    // One random chunk of text: mostly well-formed sequences, some end-of-text,
    // noise bytes and sequences cut short.
    task automatic send_random_chunk();
        int unsigned pick;
        int unsigned len;
        int unsigned keep;
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            len = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 6);
            if (len == 1)
                send_byte(BYTE_W'($urandom_range(1, 8'h7F)));
            else
            begin
                send_byte(lead_byte(len));
                repeat (len - 1)
                    send_byte(cont_byte());
            end
        end
        else if (pick < 75)
            send_byte(END_BYTE);
        else if (pick < 88)
            send_byte(BYTE_W'($urandom_range(8'hFF)));
        else
        begin
            // broken: truncated by end-of-text, or an ASCII byte where a
            // continuation belongs (still consumed as one)
            len  = $urandom_range(2, 6);
            keep = $urandom_range(len - 2);
            send_byte(lead_byte(len));
            repeat (keep)
                send_byte(cont_byte());
            if ($urandom_range(1))
                send_byte(END_BYTE);
            else
                send_byte(BYTE_W'($urandom_range(1, 8'h7F)));
        end
    endtask

    // Watchdog: ends the run when no transfer happens for too long.
    initial
    begin : watchdog
        int unsigned stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall = 0;
            else
                stall++;
        end
        $display("utf8_code_point_decoder_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [BYTE_W-1:0] directed[$];
        int unsigned       base;
        // end of text, ASCII extremes, stray continuations, FE/FF, 2/3-byte
        // forms, max six-byte form, ASCII in continuation slot, cut-off sequence
        directed = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF,
                     8'hC2, 8'hA9,
                     8'hE2, 8'h82, 8'hAC,
                     8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                     8'hC3, 8'h41,
                     8'hE2, 8'h82, 8'h00};
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_byte(directed[i]);

        base = codes_sent;
        while (codes_sent - base < RANDOM_CODES)
        begin
            calm = (codes_sent - base >= 600) && (codes_sent - base < 900);
            send_random_chunk();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (tracker.mismatch_count == 0)
            $display("utf8_code_point_decoder_tb: done, clean");
        else
            $display("utf8_code_point_decoder_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/u8d_pkg.sv
hdl/u8d_decode.sv
hdl/utf8_code_point_decoder.sv
verif/utf8_code_point_decoder_tb.sv
